// ===== design/quartile_engine_defines.svh =====
// assertion macros shared by the checker
`ifndef QUARTILE_ENGINE_DEFINES_SVH
`define QUARTILE_ENGINE_DEFINES_SVH

// same-cycle implication
`define QE_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication
`define QE_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

// ===== design/qe_pkg.sv =====
package qe_pkg;
	localparam int MaxSamples  = 1024;
	localparam int SampleWidth = 32;
	localparam int AddrWidth   = $clog2(MaxSamples);
	localparam int CountWidth  = $clog2(MaxSamples + 1);
	localparam int OutWidth    = SampleWidth + 2;

	typedef logic signed [SampleWidth-1:0] sample_t;
	typedef logic signed [OutWidth-1:0]    result_t;
	typedef logic [CountWidth-1:0]         count_t;
	typedef logic [AddrWidth-1:0]          addr_t;
endpackage

// ===== design/qe_interp.sv =====
module qe_interp (
	input  qe_pkg::sample_t v_lo,
	input  qe_pkg::sample_t v_hi,
	input  logic [1:0]      fr,
	output qe_pkg::result_t q4
);
	logic signed [qe_pkg::SampleWidth:0] diff;
	qe_pkg::result_t                     diff_x;
	qe_pkg::result_t                     base;
	qe_pkg::result_t                     step;

	always_comb begin
		diff   = $signed({v_hi[qe_pkg::SampleWidth-1], v_hi})
			- $signed({v_lo[qe_pkg::SampleWidth-1], v_lo});
		diff_x = qe_pkg::OutWidth'(diff);
		base   = {v_lo, 2'b00};
		unique case (fr)
			2'd0: step = '0;
			2'd1: step = diff_x;
			2'd2: step = diff_x <<< 1;
			default: step = diff_x + (diff_x <<< 1);
		endcase
		q4 = base + step;
	end
endmodule

// ===== design/quartile_engine.sv =====
// channel | signals                                     | beat
// --------+---------------------------------------------+---------------------------------
// in      | in_valid in_ready sample last empty_set     | one sample, or close of the set
// out     | out_valid out_ready first_quartile median   | three quartiles and flags
//         | third_quartile no_data overflowed           |
//
// loading takes a beat whenever in_ready is high; a closing beat starts the rank pass
// rank pass over n stored samples: one memory read port visits
// every sample once per pivot, counting smaller and equal samples
// an empty set closes on its closing beat with no rank pass
// reset clears count, overflow flag and control; the sample memory needs no clearing
// a waiting result stalls every input beat until it is taken
module quartile_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  qe_pkg::sample_t        sample,
	input  logic                   last,
	input  logic                   empty_set,
	output logic                   out_valid,
	input  logic                   out_ready,
	output qe_pkg::result_t        first_quartile,
	output qe_pkg::result_t        median,
	output qe_pkg::result_t        third_quartile,
	output logic                   no_data,
	output logic                   overflowed
);
	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_OUTER = 3'd1;
	localparam logic [2:0] S_PIVOT = 3'd2;
	localparam logic [2:0] S_INNER = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_CHECK = 3'd5;
	localparam logic [2:0] S_CALC  = 3'd6;

	localparam int CW = qe_pkg::CountWidth;

	// sample memory, one write and one registered read port
	qe_pkg::sample_t mem [qe_pkg::MaxSamples];
	qe_pkg::sample_t rdata_q;
	qe_pkg::addr_t   raddr;

	logic [2:0]      state_q;
	qe_pkg::count_t  cnt_q;
	logic            ovf_q;
	qe_pkg::count_t  i_q;
	qe_pkg::count_t  j_q;
	qe_pkg::count_t  less_q;
	qe_pkg::count_t  eq_q;
	qe_pkg::sample_t pivot_q;
	logic            cmp_v_s1;
	qe_pkg::sample_t vlo_q [3];
	qe_pkg::sample_t vhi_q [3];
	qe_pkg::result_t q4 [3];

	logic            in_fire;
	logic            out_free;
	logic            store;
	logic            closing;
	qe_pkg::count_t  n_after;
	qe_pkg::count_t  nm1;
	qe_pkg::count_t  lo [3];
	logic [1:0]      fr [3];
	logic [CW:0]     upper;

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_LOAD) && out_free;
	assign in_fire  = in_valid && in_ready;
	assign store    = !empty_set && (cnt_q < qe_pkg::count_t'(qe_pkg::MaxSamples));
	assign closing  = empty_set || last;
	assign n_after  = store ? cnt_q + 1'b1 : cnt_q;
	assign nm1      = cnt_q - 1'b1;
	assign upper    = {1'b0, less_q} + {1'b0, eq_q};

	// order statistic positions (q+1)*(n-1)/4, split into index and quarter fraction
	always_comb begin
		for (int q = 0; q < 3; q++) begin
			logic [CW+1:0] idx;
			idx   = (CW + 2)'(q + 1) * {2'b00, nm1};
			lo[q] = idx[CW+1:2];
			fr[q] = idx[1:0];
		end
	end

	always_comb begin
		unique case (state_q)
			S_INNER: raddr = j_q[qe_pkg::AddrWidth-1:0];
			default: raddr = i_q[qe_pkg::AddrWidth-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire && store)
			mem[cnt_q[qe_pkg::AddrWidth-1:0]] <= sample[qe_pkg::SampleWidth-1:0];
		rdata_q <= mem[raddr];
	end

	for (genvar g = 0; g < 3; g++) begin : g_interp
		qe_interp u_interp (
			.v_lo(vlo_q[g]),
			.v_hi(vhi_q[g]),
			.fr  (fr[g]),
			.q4  (q4[g])
		);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_PIVOT)
			pivot_q <= rdata_q;
		if (state_q == S_CHECK) begin
			// pivot holds every sorted position in [less, less+eq)
			for (int q = 0; q < 3; q++) begin
				if (less_q <= lo[q] && {1'b0, lo[q]} < upper)
					vlo_q[q] <= pivot_q;
				if (less_q <= lo[q] + 1'b1 && {1'b0, lo[q]} + 1'b1 < upper)
					vhi_q[q] <= pivot_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			cnt_q          <= '0;
			ovf_q          <= 1'b0;
			i_q            <= '0;
			j_q            <= '0;
			less_q         <= '0;
			eq_q           <= '0;
			cmp_v_s1       <= 1'b0;
			out_valid      <= 1'b0;
			first_quartile <= '0;
			median         <= '0;
			third_quartile <= '0;
			no_data        <= 1'b0;
			overflowed     <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;

			// compare stage, acting on the read data in the cycle after its address
			if (cmp_v_s1) begin
				if (rdata_q < pivot_q)
					less_q <= less_q + 1'b1;
				else if (rdata_q == pivot_q)
					eq_q <= eq_q + 1'b1;
			end
			cmp_v_s1 <= (state_q == S_INNER);

			unique case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						cnt_q <= n_after;
						if (!empty_set && !store)
							ovf_q <= 1'b1;
						if (closing) begin
							if (n_after == '0) begin
								// empty set answers at once
								out_valid      <= 1'b1;
								first_quartile <= '0;
								median         <= '0;
								third_quartile <= '0;
								no_data        <= 1'b1;
								overflowed     <= ovf_q || (!empty_set && !store);
								ovf_q          <= 1'b0;
							end else begin
								i_q     <= '0;
								state_q <= S_OUTER;
							end
						end
					end
				end
				S_OUTER: state_q <= S_PIVOT;
				S_PIVOT: begin
					less_q  <= '0;
					eq_q    <= '0;
					j_q     <= '0;
					state_q <= S_INNER;
				end
				S_INNER: begin
					j_q <= j_q + 1'b1;
					if (j_q == nm1)
						state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_CHECK;
				S_CHECK: begin
					if (i_q == nm1) begin
						state_q <= S_CALC;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_OUTER;
					end
				end
				S_CALC: begin
					if (out_free) begin
						out_valid      <= 1'b1;
						first_quartile <= q4[0];
						median         <= q4[1];
						third_quartile <= q4[2];
						no_data        <= 1'b0;
						overflowed     <= ovf_q;
						ovf_q          <= 1'b0;
						cnt_q          <= '0;
						state_q        <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule

// ===== design/qe_checker.sv =====
`include "quartile_engine_defines.svh"
module qe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [31:0] sample,
	input logic               last,
	input logic               empty_set,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [33:0] first_quartile,
	input logic signed [33:0] median,
	input logic signed [33:0] third_quartile,
	input logic               no_data,
	input logic               overflowed
);
	`QE_ASSERT_NOW(a_empty_zero, clk, arst_n, out_valid && no_data, first_quartile == 0 && median == 0 && third_quartile == 0)
	`QE_ASSERT_NOW(a_stall_blocks, clk, arst_n, out_valid && !out_ready, !in_ready)
	`QE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(median) && $stable(no_data))
endmodule

bind quartile_engine qe_checker u_qe_checker (.*);
